// ===== design/assert_macros.svh =====
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, held off during reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, held off during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/covt_pkg.sv =====
// Package: types, constants and register indexes of the CO2 valve timer.
package covt_pkg;

  localparam int unsigned TICK_BITS_DEF = 32;
  localparam int unsigned LEVEL_W       = 16;
  localparam int unsigned CFG_W         = 32;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned OUT_DATA_W    = 8;
  localparam int unsigned IN_USER_W     = 2;

  localparam logic [LEVEL_W-1:0] THRESHOLD_RST = '0;
  localparam logic [CFG_W-1:0]   MAX_AGE_RST   = '0;
  localparam logic [CFG_W-1:0]   MAX_OPEN_RST  = CFG_W'(1000);
  localparam logic [CFG_W-1:0]   LOCKOUT_RST   = CFG_W'(30000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CO2_THRESHOLD  = 2'd0,
    REG_MAX_SAMPLE_AGE = 2'd1,
    REG_MAX_OPEN_TICKS = 2'd2,
    REG_LOCKOUT_TICKS  = 2'd3
  } covt_reg_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_limit;
    logic [CFG_W-1:0]   max_sample_age;
    logic [CFG_W-1:0]   max_open_ticks;
    logic [CFG_W-1:0]   lockout_ticks;
  } covt_cfg_t;

endpackage

// ===== design/co2_valve_injection_timer_top.sv =====
// CO2 injection valve timer: input register, step logic and result register.
//
// Input stream (s_axis): one transaction per tick report, carrying the current
// tick and optionally one CO2 sample. Output stream (m_axis): one transaction per
// input transaction, in order, with the valve command and a start flag.
// Configuration: cfg_we_i writes cfg_data_i to the register cfg_index_i
// (0 threshold, 1 max sample age, 2 max open ticks, 3 lockout ticks); the user
// writes only while no transaction is in flight; the block does not enforce it.
// A transaction accepted on s_axis sits in the input register and is shown on
// m_axis once it moves on into the result register.
// Throughput: one transaction per cycle while m_axis does not stall;
// the valve state update is a single pass of subtract and compare logic
// between the input register and the result register.
// Reset: the valve is closed, no injection recorded, registers take their
// defaults (max open 1000, lockout 30000, others 0), both stages empty.
// Stall: while m_axis_tready is low the result holds; one more transaction
// is taken into the input register, then s_axis_tready drops.
module co2_valve_injection_timer_top #(
  parameter int unsigned TICK_BITS = covt_pkg::TICK_BITS_DEF,
  localparam int unsigned IN_DATA_W = ((2 * TICK_BITS + covt_pkg::LEVEL_W + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: now_tick, co2_level, sample_tick, zero padding
  input  logic [IN_DATA_W-1:0]             s_axis_tdata,
  // tuser: sample_present, sample_valid
  input  logic [covt_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: valve_drive, injection_started, zero padding
  output logic [covt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [covt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [covt_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int unsigned LVL_LO = TICK_BITS;
  localparam int unsigned STP_LO = TICK_BITS + covt_pkg::LEVEL_W;

  logic                           in_valid_q;
  logic [TICK_BITS-1:0]           now_q, stamp_q;
  logic [covt_pkg::LEVEL_W-1:0]   level_q;
  logic                           present_q, valid_q;
  logic                           out_valid_q, drive_q, started_q;
  logic                           advance, step, drive, started;
  covt_pkg::covt_cfg_t            cfg;

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  covt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  covt_core #(.TICK_BITS(TICK_BITS)) u_core (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .step_i              (step),
    .now_tick_i          (now_q),
    .sample_present_i    (present_q),
    .sample_valid_i      (valid_q),
    .co2_level_i         (level_q),
    .sample_tick_i       (stamp_q),
    .cfg_i               (cfg),
    .valve_drive_o       (drive),
    .injection_started_o (started)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      now_q     <= s_axis_tdata[TICK_BITS-1:0];
      level_q   <= s_axis_tdata[LVL_LO +: covt_pkg::LEVEL_W];
      stamp_q   <= s_axis_tdata[STP_LO +: TICK_BITS];
      present_q <= s_axis_tuser[0];
      valid_q   <= s_axis_tuser[1];
    end
    if (step) begin
      drive_q   <= drive;
      started_q <= started;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(covt_pkg::OUT_DATA_W - 2)'(0), started_q, drive_q};

endmodule

// ===== design/covt_cfg.sv =====
// Configuration register file of the CO2 valve timer.
module covt_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             we_i,
  input  logic [covt_pkg::CFG_IDX_W-1:0]   index_i,
  input  logic [covt_pkg::CFG_W-1:0]       data_i,
  output covt_pkg::covt_cfg_t              cfg_o
);

  covt_pkg::covt_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (covt_pkg::covt_reg_e'(index_i))
        covt_pkg::REG_CO2_THRESHOLD:  cfg_d.level_limit    = data_i[covt_pkg::LEVEL_W-1:0];
        covt_pkg::REG_MAX_SAMPLE_AGE: cfg_d.max_sample_age = data_i;
        covt_pkg::REG_MAX_OPEN_TICKS: cfg_d.max_open_ticks = data_i;
        covt_pkg::REG_LOCKOUT_TICKS:  cfg_d.lockout_ticks  = data_i;
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level_limit    <= covt_pkg::THRESHOLD_RST;
      cfg_q.max_sample_age <= covt_pkg::MAX_AGE_RST;
      cfg_q.max_open_ticks <= covt_pkg::MAX_OPEN_RST;
      cfg_q.lockout_ticks  <= covt_pkg::LOCKOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/covt_core.sv =====
// Valve state registers and the per-transaction step logic.
module covt_core #(
  parameter int unsigned TICK_BITS = covt_pkg::TICK_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic [TICK_BITS-1:0]           now_tick_i,
  input  logic                           sample_present_i,
  input  logic                           sample_valid_i,
  input  logic [covt_pkg::LEVEL_W-1:0]   co2_level_i,
  input  logic [TICK_BITS-1:0]           sample_tick_i,
  input  covt_pkg::covt_cfg_t            cfg_i,
  output logic                           valve_drive_o,
  output logic                           injection_started_o
);

  logic                 open_q, open_d;
  logic                 injected_q, injected_d;
  logic [TICK_BITS-1:0] opened_at_q, opened_at_d;
  logic [TICK_BITS-1:0] closed_at_q, closed_at_d;

  logic [TICK_BITS-1:0] max_age, max_open, lockout;
  logic [TICK_BITS-1:0] open_time, age, since_close, closed_mid;
  logic                 forced, open_mid, good, allow, started;

  // registers are taken modulo the tick width
  assign max_age  = TICK_BITS'(cfg_i.max_sample_age);
  assign max_open = TICK_BITS'(cfg_i.max_open_ticks);
  assign lockout  = TICK_BITS'(cfg_i.lockout_ticks);

  assign open_time   = now_tick_i - opened_at_q;
  assign forced      = open_q && (open_time >= max_open);
  assign open_mid    = open_q && !forced;
  assign closed_mid  = forced ? now_tick_i : closed_at_q;

  assign age         = now_tick_i - sample_tick_i;
  assign good        = sample_valid_i && (co2_level_i < cfg_i.level_limit) && (age <= max_age);
  assign since_close = now_tick_i - closed_mid;
  assign allow       = !open_mid && (!injected_q || (since_close >= lockout));
  assign started     = sample_present_i && good && allow;

  always_comb begin
    open_d      = open_mid;
    injected_d  = injected_q;
    opened_at_d = opened_at_q;
    closed_at_d = closed_mid;
    if (sample_present_i) begin
      if (good) begin
        if (allow) begin
          open_d      = 1'b1;
          injected_d  = 1'b1;
          opened_at_d = now_tick_i;
        end
      end else begin
        // close, stamping the time only if it was still open
        if (open_mid) closed_at_d = now_tick_i;
        open_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      injected_q  <= 1'b0;
      opened_at_q <= '0;
      closed_at_q <= '0;
    end else if (step_i) begin
      open_q      <= open_d;
      injected_q  <= injected_d;
      opened_at_q <= opened_at_d;
      closed_at_q <= closed_at_d;
    end
  end

  assign valve_drive_o       = open_d;
  assign injection_started_o = started;

endmodule

// ===== design/covt_checker.sv =====
// Port-level checker for the CO2 valve timer, bound to the top level.
`include "assert_macros.svh"

module covt_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [covt_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  // a start always leaves the valve open
  `ASSERT_IMPL(a_start_opens, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[0])

  // with the result register empty the input side must be ready
  `ASSERT_IMPL(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
               m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind co2_valve_injection_timer_top covt_checker u_covt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
